// File: sv/kdb_pkg.sv
`default_nettype none

package kdb_pkg;

  // Number of keys handled side by side, and the fixed width of the level and mask fields.
  localparam int unsigned NumKeys = 4;
  localparam int unsigned InW     = 4;
  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDebounce = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLong     = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [TickW-1:0] DebounceRst = 16'd2;
  localparam logic [TickW-1:0] LongRst     = 16'd100;

  // Per-key phase codes.
  localparam logic [1:0] PhIdle     = 2'd0;
  localparam logic [1:0] PhDebounce = 2'd1;
  localparam logic [1:0] PhPressed  = 2'd2;
  localparam logic [1:0] PhLong     = 2'd3;

  // Events that one key reports for one tick.
  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } kdb_evt_t;

endpackage

`default_nettype wire

// File: sv/kdb_lane.sv
`default_nettype none

module kdb_lane (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          pressed_i,
  input  wire  [kdb_pkg::TickW-1:0]    debounce_i,
  input  wire  [kdb_pkg::TickW-1:0]    long_i,
  output kdb_pkg::kdb_evt_t            evt_o
);
  import kdb_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic [TickW-1:0] ticks_q, ticks_d;
  logic [TickW-1:0] base;
  kdb_evt_t         evt;

  // Phase step for one tick; the counter is then cleared or kept, and advanced by one.
  always_comb begin
    phase_d       = phase_q;
    base          = ticks_q;
    evt.short_hit = 1'b0;
    evt.long_hit  = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (pressed_i) phase_d = PhDebounce;
        base = '0;
      end
      PhDebounce: begin
        if (!pressed_i) begin
          phase_d = PhIdle;
        end else if (ticks_q >= debounce_i) begin
          phase_d = PhPressed;
          base    = '0;
        end
      end
      PhPressed: begin
        if (!pressed_i) begin
          evt.short_hit = 1'b1;
          phase_d       = PhIdle;
          base          = '0;
        end else if (ticks_q >= long_i) begin
          evt.long_hit = 1'b1;
          phase_d      = PhLong;
        end
      end
      default: begin
        if (!pressed_i) phase_d = PhIdle;
        else base = '0;
      end
    endcase
    ticks_d = base + TickW'(1);
  end

  assign evt_o = en_i ? evt : '0;

  // The state only moves on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ticks_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

`ifndef SYNTHESIS
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(evt_o.short_hit && evt_o.long_hit))
    else $error("key reports short and long press in the same tick");
  a_short_from_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.short_hit |=> phase_q == PhIdle && ticks_q == TickW'(1))
    else $error("short press did not return the key to idle");
  a_long_enters_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.long_hit |=> phase_q == PhLong)
    else $error("long press did not enter the long-active phase");
`endif

endmodule

`default_nettype wire

// File: sv/kdb_out.sv
`default_nettype none

module kdb_out (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         push_i,
  input  wire kdb_pkg::kdb_evt_t [kdb_pkg::NumKeys-1:0] evt_i,
  output logic                                        full_o,
  output logic                                        out_valid_o,
  input  wire                                         out_stall_i,
  output logic [kdb_pkg::InW-1:0]                     short_mask_o,
  output logic [kdb_pkg::InW-1:0]                     long_mask_o
);
  import kdb_pkg::*;

  logic [InW-1:0] mask_short, mask_long;
  logic [2*InW-1:0] head_q, head_d, tail_q, tail_d, entry_new;
  logic [1:0] count_q, count_d;
  logic pop;

  // Merge the lane events into one mask per kind; keys beyond the field width are dropped.
  for (genvar g = 0; g < InW; g++) begin : g_merge
    if (g < NumKeys) begin : g_key
      assign mask_short[g] = evt_i[g].short_hit;
      assign mask_long[g]  = evt_i[g].long_hit;
    end else begin : g_none
      assign mask_short[g] = 1'b0;
      assign mask_long[g]  = 1'b0;
    end
  end

  assign entry_new = {mask_short, mask_long};
  assign pop       = out_valid_o && !out_stall_i;

  // Two-entry output queue, so a new tick is taken while a result waits.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    unique case ({push_i, pop})
      2'b11: begin
        if (count_q == 2'd1) begin
          head_d = entry_new;
        end else begin
          head_d = tail_q;
          tail_d = entry_new;
        end
      end
      2'b10: begin
        if (count_q == 2'd0) head_d = entry_new;
        else tail_d = entry_new;
        count_d = count_q + 2'd1;
      end
      2'b01: begin
        head_d  = tail_q;
        count_d = count_q - 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign full_o       = count_q == 2'd2;
  assign out_valid_o  = count_q != 2'd0;
  assign short_mask_o = head_q[2*InW-1:InW];
  assign long_mask_o  = head_q[InW-1:0];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("transaction pushed into a full output queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |=> count_q == $past(count_q) + 2'd1)
    else $error("output queue lost a transaction");
`endif

endmodule

`default_nettype wire

// File: sv/key_debounce_short_long_press.sv
// Key debouncer with short and long press detection.
// Input channel: each transaction is one tick carrying raw_levels_i, the active-low
// pin levels of all keys (0 means pressed). A transaction is taken when
// in_valid_i is high and in_stall_o is low.
// Output channel: exactly one transaction per input tick, carrying short_mask_o
// (keys released from the pressed phase) and long_mask_o (keys reaching the long
// press). A transaction completes when out_valid_o is high and out_stall_i is low.
// The result of a tick is registered into the output queue when the tick is taken.
// Throughput is one tick per cycle; the per-key phase update runs in four lanes
// in parallel, and a two-entry output queue decouples the channels, so in_stall_o
// rises only when two results wait behind a stalled receiver.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 is the
// debounce count, 1 the long-press count); write only while the block is idle.
// Reset clears every key to idle with a zero counter, empties the output queue and
// loads the counts 2 and 100.
`default_nettype none

module key_debounce_short_long_press (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [kdb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [kdb_pkg::TickW-1:0]        cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [kdb_pkg::InW-1:0]          raw_levels_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [kdb_pkg::InW-1:0]          short_mask_o,
  output logic [kdb_pkg::InW-1:0]          long_mask_o
);
  import kdb_pkg::*;

  logic [TickW-1:0] debounce_q, long_q;
  logic             accept;
  logic             full;
  kdb_evt_t [NumKeys-1:0] evt;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      long_q     <= LongRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce: debounce_q <= cfg_data_i;
        CfgLong:     long_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // One lane per key; a key without an input bit reads as released.
  for (genvar g = 0; g < NumKeys; g++) begin : g_lane
    logic pressed;
    if (g < InW) begin : g_pin
      assign pressed = !raw_levels_i[g];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end
    kdb_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .pressed_i  (pressed),
      .debounce_i (debounce_q),
      .long_i     (long_q),
      .evt_o      (evt[g])
    );
  end

  // Merge the lane events and queue the result.
  kdb_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .evt_i        (evt),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .short_mask_o (short_mask_o),
    .long_mask_o  (long_mask_o)
  );

endmodule

`default_nettype wire
